### src/ps2_mouse_packet_tracker_unit_macros.svh
// Assertion macros used by the packet tracker checker
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PS2MPT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PS2MPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/ps2mpt_pkg.sv
// Package: shared types and constants of the PS/2 mouse packet tracker
`default_nettype none
package ps2mpt_pkg;

  localparam int CFG_BITS = 12;

  localparam logic [7:0] ACK_BYTE  = 8'hFA;
  localparam logic [7:0] HDR_MASK  = 8'hC8;
  localparam logic [7:0] HDR_MATCH = 8'h08;

  localparam logic [0:0] CFG_MAX_X = 1'b0;
  localparam logic [0:0] CFG_MAX_Y = 1'b1;

  localparam logic [CFG_BITS-1:0] MAX_X_RESET = 12'd800;
  localparam logic [CFG_BITS-1:0] MAX_Y_RESET = 12'd600;

  typedef struct packed {
    logic              valid;
    logic [2:0]        buttons;
    logic signed [8:0] delta_x;
    logic signed [9:0] delta_y;
  } pkt_t;

endpackage
`default_nettype wire

### src/ps2mpt_frame.sv
// Byte framer: acknowledge wait, header sync and packet assembly
`default_nettype none
module ps2mpt_frame (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  output ps2mpt_pkg::pkt_t pkt,
  output logic             y_phase
);
  import ps2mpt_pkg::*;

  localparam logic [1:0] PH_ACK = 2'd0;
  localparam logic [1:0] PH_HDR = 2'd1;
  localparam logic [1:0] PH_X   = 2'd2;
  localparam logic [1:0] PH_Y   = 2'd3;

  logic [1:0] phase, phase_next;
  logic [7:0] header_byte;
  logic [7:0] x_byte;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_ACK: if (rx_byte == ACK_BYTE) phase_next = PH_HDR;
      PH_HDR: if ((rx_byte & HDR_MASK) == HDR_MATCH) phase_next = PH_X;
      PH_X:   phase_next = PH_Y;
      PH_Y:   phase_next = PH_HDR;
      default: phase_next = PH_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ACK;
      header_byte <= '0;
      x_byte      <= '0;
    end else if (take) begin
      phase <= phase_next;
      if (phase == PH_HDR && phase_next == PH_X) header_byte <= rx_byte;
      if (phase == PH_X) x_byte <= rx_byte;
    end
  end

  assign y_phase     = (phase == PH_Y);
  assign pkt.valid   = take && y_phase;
  assign pkt.buttons = header_byte[2:0];
  assign pkt.delta_x = $signed({header_byte[4], x_byte});
  assign pkt.delta_y = -$signed({header_byte[5], header_byte[5], rx_byte});
endmodule
`default_nettype wire

### src/ps2mpt_clamp.sv
// One cursor axis: add the delta and clamp to 0..limit
`default_nettype none
module ps2mpt_clamp #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [COORD_BITS-1:0]           cur,
  input  wire logic signed [9:0]               delta,
  input  wire logic [ps2mpt_pkg::CFG_BITS-1:0] max_val,
  output logic [COORD_BITS-1:0]                pos
);
  import ps2mpt_pkg::*;

  localparam int LW = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam int SW = COORD_BITS + 2;

  logic [LW-1:0]         max_ext;
  logic [LW-1:0]         mask_ext;
  logic [COORD_BITS-1:0] limit;
  logic signed [SW-1:0]  sum;

  always_comb begin
    max_ext  = LW'(max_val);
    mask_ext = LW'({COORD_BITS{1'b1}});
    limit    = (max_ext > mask_ext) ? {COORD_BITS{1'b1}} : max_ext[COORD_BITS-1:0];
    sum      = $signed({2'b00, cur}) + SW'(delta);
    priority if (sum < 0) begin
      pos = '0;
    end else if (sum > $signed({2'b00, limit})) begin
      pos = limit;
    end else begin
      pos = sum[COORD_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

### src/ps2_mouse_packet_tracker_unit.sv
// Top level: PS/2 mouse packet tracker with cursor position and clamp
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | rx_byte
//  m_axis    | out       | buttons, delta_x, delta_y, pos_x, pos_y
//  cfg       | in        | max_x (index 0), max_y (index 1)
//
// A packet result lands in the output register on the edge that takes the
// Y byte; bytes flow at one byte per cycle unless a waiting result holds off a Y byte.
// The cursor add and clamp sit between the cursor registers and that register.
// Reset (synchronous) returns to the acknowledge wait with the cursor at 0.
// A waiting result only holds off a Y byte; other bytes are still taken.
`default_nettype none
module ps2_mouse_packet_tracker_unit #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [ps2mpt_pkg::CFG_BITS-1:0]  cfg_data,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // rx_byte
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // buttons, delta_x, delta_y, pos_x, pos_y, zero fill
  output logic [((22+2*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata
);
  import ps2mpt_pkg::*;

  localparam int OUT_BITS = ((22 + 2*COORD_BITS + 7) / 8) * 8;

  logic [CFG_BITS-1:0]   max_x;
  logic [CFG_BITS-1:0]   max_y;
  logic [COORD_BITS-1:0] cursor_x, cursor_y;
  logic [COORD_BITS-1:0] pos_x_next, pos_y_next;
  logic                  take;
  logic                  y_phase;
  pkt_t                  pkt;

  logic [2:0]            buttons;
  logic signed [8:0]     delta_x;
  logic signed [9:0]     delta_y;

  assign s_axis_tready = !y_phase || !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= MAX_X_RESET;
      max_y <= MAX_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_X: max_x <= cfg_data;
        CFG_MAX_Y: max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  ps2mpt_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (s_axis_tdata),
    .pkt     (pkt),
    .y_phase (y_phase)
  );

  ps2mpt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .cur     (cursor_x),
    .delta   (10'(pkt.delta_x)),
    .max_val (max_x),
    .pos     (pos_x_next)
  );

  ps2mpt_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .cur     (cursor_y),
    .delta   (pkt.delta_y),
    .max_val (max_y),
    .pos     (pos_y_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      cursor_x      <= '0;
      cursor_y      <= '0;
    end else if (pkt.valid) begin
      m_axis_tvalid <= 1'b1;
      cursor_x      <= pos_x_next;
      cursor_y      <= pos_y_next;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid) begin
      buttons <= pkt.buttons;
      delta_x <= pkt.delta_x;
      delta_y <= pkt.delta_y;
    end
  end

  assign m_axis_tdata = OUT_BITS'({cursor_y, cursor_x, delta_y, delta_x, buttons});
endmodule
`default_nettype wire

### src/ps2mpt_checker.sv
// Port checker for the packet tracker, bound to the top level
`default_nettype none
`include "ps2_mouse_packet_tracker_unit_macros.svh"
module ps2mpt_checker #(
  parameter int OUT_BITS = 48
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OUT_BITS-1:0] m_axis_tdata
);
  `PS2MPT_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `PS2MPT_ASSERT_NOW(a_out_cause, clk, rst, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready), "result without an input transaction")
  `PS2MPT_ASSERT_NOW(a_reset_idle, clk, rst, $past(rst), s_axis_tready && !m_axis_tvalid, "not idle after reset")
  `PS2MPT_ASSERT_NOW(a_in_free, clk, rst, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker #(.OUT_BITS(OUT_BITS)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
